@@ src/wcss_pkg.sv @@
// ----------------------------------------------------------------------------
// wcss_pkg
// shared types and constants for the weighted candidate score/select block
// ----------------------------------------------------------------------------
package wcss_pkg;

	localparam int MAX_CANDIDATES_DEF = 16;

	// configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LOCALITY_BONUS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_FIRST_BONUS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_COST_DIVISOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_COST_DIVISOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_PENALTY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_DATA_BONUS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_BONUS      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_PENALTY   = 3'd7;

	// field widths
	localparam int IDX_W   = 4;
	localparam int SCORE_W = 16;
	localparam int DIV_W   = 7;
	localparam int KEY_W   = 64;

	// reason codes
	localparam logic [2:0] RSN_OK          = 3'd0;
	localparam logic [2:0] RSN_BAD_WEIGHTS = 3'd1;
	localparam logic [2:0] RSN_UNAVAILABLE = 3'd2;
	localparam logic [2:0] RSN_LOCAL_ONLY  = 3'd3;
	localparam logic [2:0] RSN_NET_DENIED  = 3'd4;
	localparam logic [2:0] RSN_REMOTE_DENY = 3'd5;
	localparam logic [2:0] RSN_OVERFLOW    = 3'd6;

	// engine states
	localparam logic [1:0] ENG_AVAILABLE   = 2'd0;
	localparam logic [1:0] ENG_DEGRADED    = 2'd1;
	localparam logic [1:0] ENG_OFFLINE     = 2'd2;
	localparam logic [1:0] ENG_MAINTENANCE = 2'd3;

	// engine flag bits
	localparam int EF_LOCAL   = 0;
	localparam int EF_PRIVATE = 1;
	localparam int EF_NETWORK = 2;
	localparam int EF_REMOTE  = 3;
	localparam int EF_RANGE   = 4;

	// job flag bits
	localparam int JF_LOCAL_FIRST = 0;
	localparam int JF_LOCAL_ONLY  = 1;
	localparam int JF_NET_OK      = 2;
	localparam int JF_REMOTE_OK   = 3;
	localparam int JF_RANGE       = 4;

	localparam logic [7:0] WEIGHT_MAX = 8'd100;
	localparam logic signed [SCORE_W-1:0] ESCALATE_BELOW = 16'sd50;
	localparam logic signed [SCORE_W:0]   ESCALATE_GAP   = 17'sd5;

	typedef struct packed {
		logic [7:0]              quality;
		logic [7:0]              gpu_load_weight;
		logic [7:0]              cpu_load_weight;
		logic [1:0]              engine_state;
		logic [4:0]              engine_flags;
		logic [KEY_W-1:0]        engine_key_low;
		logic [KEY_W-1:0]        engine_key_high;
		logic signed [7:0]       predicted_delta;
		logic [4:0]              job_flags;
		logic [KEY_W-1:0]        job_key_low;
		logic [KEY_W-1:0]        job_key_high;
		logic                    last;
	} cand_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]          candidate_index;
		logic                      feasible;
		logic [2:0]                reason_code;
		logic signed [SCORE_W-1:0] score;
		logic                      plan_done;
		logic [IDX_W-1:0]          chosen_index;
		logic                      plan_status;
		logic                      escalate_flag;
	} verdict_word_t;

endpackage

@@ src/wcss_cand_if.sv @@
// ----------------------------------------------------------------------------
// wcss_cand_if
// valid/ready channel carrying one candidate word
// ----------------------------------------------------------------------------
interface wcss_cand_if;
	import wcss_pkg::*;

	logic       valid;
	logic       ready;
	cand_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/wcss_verdict_if.sv @@
// ----------------------------------------------------------------------------
// wcss_verdict_if
// valid/ready channel carrying one verdict word
// ----------------------------------------------------------------------------
interface wcss_verdict_if;
	import wcss_pkg::*;

	logic          valid;
	logic          ready;
	verdict_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/weighted_candidate_score_select_top.sv @@
// ----------------------------------------------------------------------------
// weighted_candidate_score_select_top
// scores candidate engines of a plan and picks the best one
// ----------------------------------------------------------------------------
// Each candidate word gets hard checks (weights, availability, local-only,
// network, remote) and the first failing check gives the reason code. A
// feasible candidate is scored from quality, locality, the two cost quotients,
// degradation, privacy, key-range overlap and the predicted delta. The plan
// keeps the first maximum and the best of the other scores; the word marked
// last also carries the selected index, the status and the escalation flag,
// and then the plan clears. Words past MAX_CANDIDATES report overflow and are
// not counted. Sequence: a feasible word goes from accept through the prep
// state, the shared restoring divider for the gpu and cpu quotients, the
// update state and the result state back to the next accept; an infeasible
// or overflow word skips the divider. The divider, one bit per cycle, sets
// the pace for feasible words. A finished verdict waits in the output
// register, so the next word is taken while it is still unread; the result
// cycle stalls only if the previous verdict is still held.
// ----------------------------------------------------------------------------
module weighted_candidate_score_select_top #(
	parameter int MAX_CANDIDATES = wcss_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wcss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wcss_pkg::CFG_W-1:0]     cfg_data,
	wcss_cand_if.sink                     cand,
	wcss_verdict_if.source                verdict
);
	import wcss_pkg::*;

	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam int POS_W = $clog2(MAX_CANDIDATES);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	function automatic logic signed [SCORE_W-1:0] sx_cfg(input logic signed [CFG_W-1:0] v);
		return {{(SCORE_W-CFG_W){v[CFG_W-1]}}, v};
	endfunction

	// configuration registers
	logic signed [CFG_W-1:0] locality_bonus_q;
	logic signed [CFG_W-1:0] local_first_bonus_q;
	logic [DIV_W-1:0]        gpu_div_q;
	logic [DIV_W-1:0]        cpu_div_q;
	logic signed [CFG_W-1:0] degraded_penalty_q;
	logic signed [CFG_W-1:0] private_bonus_q;
	logic signed [CFG_W-1:0] overlap_bonus_q;
	logic signed [CFG_W-1:0] mismatch_penalty_q;

	// sequencer and item
	logic [2:0]   state_q;
	cand_word_t   item_q;
	logic [2:0]   reason_q;
	logic         ovf_q;
	logic [POS_W-1:0] pos_q;
	logic [KEY_W-1:0] lo_q;
	logic [KEY_W-1:0] hi_q;
	logic         both_rng_q;
	logic signed [SCORE_W-1:0] sum_q;

	// shared divider
	logic [DIV_W-1:0] rem_q;
	logic [7:0]       quo_q;
	logic [3:0]       step_q;

	// plan state
	logic [CNT_W-1:0]          item_count_q;
	logic signed [SCORE_W-1:0] best_value_q;
	logic [POS_W-1:0]          best_pos_q;
	logic                      best_valid_q;
	logic signed [SCORE_W-1:0] runner_value_q;
	logic                      runner_valid_q;

	// output register
	logic          verdict_valid_q;
	verdict_word_t verdict_q;

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locality_bonus_q    <= '0;
			local_first_bonus_q <= '0;
			gpu_div_q           <= DIV_W'(1);
			cpu_div_q           <= DIV_W'(1);
			degraded_penalty_q  <= '0;
			private_bonus_q     <= '0;
			overlap_bonus_q     <= '0;
			mismatch_penalty_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCALITY_BONUS:     locality_bonus_q    <= cfg_data;
				REG_LOCAL_FIRST_BONUS:  local_first_bonus_q <= cfg_data;
				REG_GPU_COST_DIVISOR:   gpu_div_q           <= cfg_data[DIV_W-1:0];
				REG_CPU_COST_DIVISOR:   cpu_div_q           <= cfg_data[DIV_W-1:0];
				REG_DEGRADED_PENALTY:   degraded_penalty_q  <= cfg_data;
				REG_PRIVATE_DATA_BONUS: private_bonus_q     <= cfg_data;
				REG_OVERLAP_BONUS:      overlap_bonus_q     <= cfg_data;
				REG_MISMATCH_PENALTY:   mismatch_penalty_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// prep: hard checks, base score, range bounds
	// ------------------------------------------------------------------
	logic [4:0]                ef;
	logic [4:0]                jf;
	logic                      ovf;
	logic [2:0]                reason;
	logic signed [SCORE_W-1:0] base_sum;

	assign ef  = item_q.engine_flags;
	assign jf  = item_q.job_flags;
	assign ovf = item_count_q >= CNT_W'(MAX_CANDIDATES);

	always_comb begin
		if (ovf)
			reason = RSN_OVERFLOW;
		else if (item_q.quality > WEIGHT_MAX || item_q.gpu_load_weight > WEIGHT_MAX ||
		         item_q.cpu_load_weight > WEIGHT_MAX)
			reason = RSN_BAD_WEIGHTS;
		else if (item_q.engine_state inside {ENG_OFFLINE, ENG_MAINTENANCE})
			reason = RSN_UNAVAILABLE;
		else if (jf[JF_LOCAL_ONLY] && !ef[EF_LOCAL])
			reason = RSN_LOCAL_ONLY;
		else if (ef[EF_NETWORK] && !jf[JF_NET_OK])
			reason = RSN_NET_DENIED;
		else if (ef[EF_REMOTE] && !jf[JF_REMOTE_OK])
			reason = RSN_REMOTE_DENY;
		else
			reason = RSN_OK;
	end

	// feasible scores stay within about +-5400, so 16 bits never clamp
	always_comb begin
		base_sum = $signed({{(SCORE_W-8){1'b0}}, item_q.quality})
		         + {{(SCORE_W-8){item_q.predicted_delta[7]}}, item_q.predicted_delta};
		if (ef[EF_LOCAL])
			base_sum = base_sum + sx_cfg(locality_bonus_q);
		if (ef[EF_LOCAL] && jf[JF_LOCAL_FIRST])
			base_sum = base_sum + sx_cfg(local_first_bonus_q);
		if (item_q.engine_state == ENG_DEGRADED)
			base_sum = base_sum + sx_cfg(degraded_penalty_q);
		if (ef[EF_PRIVATE])
			base_sum = base_sum + sx_cfg(private_bonus_q);
	end

	// ------------------------------------------------------------------
	// shared restoring divider, one quotient bit per cycle
	// ------------------------------------------------------------------
	logic [DIV_W-1:0] div_raw;
	logic [DIV_W-1:0] div_eff;
	logic [7:0]       trial;
	logic [7:0]       trial_diff;
	logic             take;
	logic [DIV_W-1:0] rem_nx;
	logic [7:0]       quo_nx;
	logic signed [SCORE_W-1:0] range_term;

	assign div_raw    = step_q[3] ? cpu_div_q : gpu_div_q;
	assign div_eff    = (div_raw == '0) ? DIV_W'(1) : div_raw;
	assign trial      = {rem_q, quo_q[7]};
	assign trial_diff = trial - {1'b0, div_eff};
	assign take       = trial >= {1'b0, div_eff};
	assign rem_nx     = take ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
	assign quo_nx     = {quo_q[6:0], take};

	always_comb begin
		if (!both_rng_q)
			range_term = '0;
		else if (lo_q <= hi_q)
			range_term = sx_cfg(overlap_bonus_q);
		else
			range_term = sx_cfg(mismatch_penalty_q);
	end

	// ------------------------------------------------------------------
	// plan summary from the updated plan state
	// ------------------------------------------------------------------
	logic signed [SCORE_W:0] best_gap;
	logic                    escalate;
	logic                    res_load;
	logic [POS_W+IDX_W-1:0]  pos_ext;
	logic [POS_W+IDX_W-1:0]  best_ext;

	assign best_gap = {best_value_q[SCORE_W-1], best_value_q}
	                - {runner_value_q[SCORE_W-1], runner_value_q};
	assign escalate = (best_value_q < ESCALATE_BELOW) ||
	                  (runner_valid_q && best_gap <= ESCALATE_GAP);
	assign res_load = (state_q == ST_RESULT) && (!verdict_valid_q || verdict.ready);
	assign pos_ext  = {{IDX_W{1'b0}}, pos_q};
	assign best_ext = {{IDX_W{1'b0}}, best_pos_q};

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			step_q          <= '0;
			item_count_q    <= '0;
			best_value_q    <= '0;
			best_pos_q      <= '0;
			best_valid_q    <= 1'b0;
			runner_value_q  <= '0;
			runner_valid_q  <= 1'b0;
			verdict_valid_q <= 1'b0;
		end else begin
			// a new verdict replaces the one read out in the same cycle
			if (res_load)
				verdict_valid_q <= 1'b1;
			else if (verdict.valid && verdict.ready)
				verdict_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cand.valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					step_q  <= '0;
					state_q <= (reason == RSN_OK) ? ST_DIV : ST_UPDATE;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (!ovf_q)
						item_count_q <= item_count_q + CNT_W'(1);
					if (reason_q == RSN_OK) begin
						if (!best_valid_q || sum_q > best_value_q) begin
							if (best_valid_q) begin
								runner_value_q <= best_value_q;
								runner_valid_q <= 1'b1;
							end
							best_value_q <= sum_q;
							best_pos_q   <= pos_q;
							best_valid_q <= 1'b1;
						end else if (!runner_valid_q || sum_q > runner_value_q) begin
							runner_value_q <= sum_q;
							runner_valid_q <= 1'b1;
						end
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
						// last word closes the plan
						if (item_q.last) begin
							item_count_q   <= '0;
							best_value_q   <= '0;
							best_pos_q     <= '0;
							best_valid_q   <= 1'b0;
							runner_value_q <= '0;
							runner_valid_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cand.valid && cand.ready)
			item_q <= cand.data;

		case (state_q)
			ST_PREP: begin
				reason_q   <= reason;
				ovf_q      <= ovf;
				pos_q      <= ovf ? '0 : item_count_q[POS_W-1:0];
				lo_q       <= (item_q.job_key_low > item_q.engine_key_low) ?
				              item_q.job_key_low : item_q.engine_key_low;
				hi_q       <= (item_q.job_key_high < item_q.engine_key_high) ?
				              item_q.job_key_high : item_q.engine_key_high;
				both_rng_q <= jf[JF_RANGE] && ef[EF_RANGE];
				sum_q      <= base_sum;
				rem_q      <= '0;
				quo_q      <= item_q.gpu_load_weight;
			end
			ST_DIV: begin
				if (step_q[2:0] == 3'd7) begin
					// quotient done: subtract it, reload for the cpu weight
					sum_q <= sum_q - $signed({{(SCORE_W-8){1'b0}}, quo_nx});
					rem_q <= '0;
					quo_q <= item_q.cpu_load_weight;
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					if (step_q == 4'd0)
						sum_q <= sum_q + range_term;
				end
			end
			ST_RESULT: begin
				if (res_load) begin
					verdict_q.candidate_index <= pos_ext[IDX_W-1:0];
					verdict_q.feasible        <= (reason_q == RSN_OK);
					verdict_q.reason_code     <= reason_q;
					verdict_q.score           <= (reason_q == RSN_OK) ? sum_q : '1;
					verdict_q.plan_done       <= item_q.last;
					verdict_q.chosen_index    <= (item_q.last && best_valid_q) ?
					                             best_ext[IDX_W-1:0] : '0;
					verdict_q.plan_status     <= item_q.last && !best_valid_q;
					verdict_q.escalate_flag   <= item_q.last && best_valid_q && escalate;
				end
			end
			default: ;
		endcase
	end

	assign cand.ready    = (state_q == ST_IDLE);
	assign verdict.valid = verdict_valid_q;
	assign verdict.data  = verdict_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_count_q <= CNT_W'(MAX_CANDIDATES))
		else $error("plan count beyond capacity");

	a_runner_needs_best: assert property (@(posedge clk) disable iff (!arst_n)
		runner_valid_q |-> best_valid_q)
		else $error("runner-up held without a best candidate");

	a_best_order: assert property (@(posedge clk) disable iff (!arst_n)
		(best_valid_q && runner_valid_q) |-> (best_value_q >= runner_value_q))
		else $error("runner-up score above best score");

	a_plan_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && item_q.last) |=> (item_count_q == '0 && !best_valid_q &&
		!runner_valid_q))
		else $error("plan state not cleared after last word");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for weighted_candidate_score_select_top
// ----------------------------------------------------------------------------
// Candidate words go in on the cand channel and verdict words come back on
// the verdict channel, one verdict per candidate. A scoreboard object tracks
// the plan state and the register settings, works out each verdict when its
// candidate is accepted, and compares every field of each returned verdict
// with the oldest one pending. A short directed plan set covers the checks,
// the scoring terms, ties, overflow and the summary cases. Random plans follow
// under several register settings, extremes among them. Both channels idle
// at random; one phase runs with no idling, and once the verdict side holds
// off long enough for the block to back up onto its input.
// ----------------------------------------------------------------------------
module tb;
	import wcss_pkg::*;

	localparam int  NUM_REGS      = 8;
	localparam int  CYCLE_LIMIT   = 500000;
	localparam int  HOLD_CYCLES   = 400;
	localparam int  HOLD_AFTER    = 300;
	localparam int  PHASE_WORDS   = 225;
	localparam int  NUM_PHASES    = 7;
	localparam int  TAIL_CYCLES   = 40;
	localparam logic [KEY_W-1:0] KEY_TOP = '1;

	// a job that allows everything and declares a key range
	localparam logic [4:0] JOB_OPEN = (5'd1 << JF_LOCAL_FIRST) | (5'd1 << JF_NET_OK) |
		(5'd1 << JF_REMOTE_OK) | (5'd1 << JF_RANGE);

	typedef logic [CFG_W-1:0] reg_set_t [NUM_REGS];

	// ------------------------------------------------------------------------
	// plan scoreboard: keeps its own plan state and register copy, predicts
	// the verdict for each accepted candidate and checks returned verdicts
	// ------------------------------------------------------------------------
	class plan_scoreboard;
		logic [CFG_W-1:0] regs [NUM_REGS];
		int filled, best, best_pos, runner;
		bit best_ok, runner_ok;
		verdict_word_t verdicts_due [$];
		int errors, words_seen, verdicts_checked, plans_done;
		int feasible_seen, overflow_seen, escalations;

		function new();
			foreach (regs[i]) regs[i] = '0;
			regs[REG_GPU_COST_DIVISOR] = CFG_W'(1);
			regs[REG_CPU_COST_DIVISOR] = CFG_W'(1);
			filled = 0; best = 0; best_pos = 0; runner = 0;
			best_ok = 0; runner_ok = 0;
			errors = 0; words_seen = 0; verdicts_checked = 0; plans_done = 0;
			feasible_seen = 0; overflow_seen = 0; escalations = 0;
		endfunction

		function void set_reg(int idx, logic [CFG_W-1:0] value);
			regs[idx] = value;
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		// accepted candidate: run the checks, score, update the plan
		function void note(cand_word_t w);
			verdict_word_t e;
			logic [2:0] why;
			int s, gd, cd;
			logic [KEY_W-1:0] lo, hi;
			e = '0;
			s = -1;
			why = RSN_OK;
			words_seen++;
			if (filled >= MAX_CANDIDATES_DEF) begin
				why = RSN_OVERFLOW;
				overflow_seen++;
			end else begin
				e.candidate_index = filled[IDX_W-1:0];
				filled++;
				if (w.quality > WEIGHT_MAX || w.gpu_load_weight > WEIGHT_MAX ||
						w.cpu_load_weight > WEIGHT_MAX)
					why = RSN_BAD_WEIGHTS;
				else if (w.engine_state == ENG_OFFLINE || w.engine_state == ENG_MAINTENANCE)
					why = RSN_UNAVAILABLE;
				else if (w.job_flags[JF_LOCAL_ONLY] && !w.engine_flags[EF_LOCAL])
					why = RSN_LOCAL_ONLY;
				else if (w.engine_flags[EF_NETWORK] && !w.job_flags[JF_NET_OK])
					why = RSN_NET_DENIED;
				else if (w.engine_flags[EF_REMOTE] && !w.job_flags[JF_REMOTE_OK])
					why = RSN_REMOTE_DENY;
				if (why == RSN_OK) begin
					// zero divisor behaves as one
					gd = int'(regs[REG_GPU_COST_DIVISOR][DIV_W-1:0]);
					cd = int'(regs[REG_CPU_COST_DIVISOR][DIV_W-1:0]);
					if (gd == 0) gd = 1;
					if (cd == 0) cd = 1;
					s = int'(w.quality);
					if (w.engine_flags[EF_LOCAL]) begin
						s += int'($signed(regs[REG_LOCALITY_BONUS]));
						if (w.job_flags[JF_LOCAL_FIRST])
							s += int'($signed(regs[REG_LOCAL_FIRST_BONUS]));
					end
					s -= int'(w.gpu_load_weight) / gd;
					s -= int'(w.cpu_load_weight) / cd;
					if (w.engine_state == ENG_DEGRADED)
						s += int'($signed(regs[REG_DEGRADED_PENALTY]));
					if (w.engine_flags[EF_PRIVATE])
						s += int'($signed(regs[REG_PRIVATE_DATA_BONUS]));
					if (w.job_flags[JF_RANGE] && w.engine_flags[EF_RANGE]) begin
						lo = (w.job_key_low > w.engine_key_low) ? w.job_key_low : w.engine_key_low;
						hi = (w.job_key_high < w.engine_key_high) ? w.job_key_high
							: w.engine_key_high;
						s += (lo <= hi) ? int'($signed(regs[REG_OVERLAP_BONUS]))
							: int'($signed(regs[REG_MISMATCH_PENALTY]));
					end
					s += int'($signed(w.predicted_delta));
					if (s > 32767) s = 32767;
					else if (s < -32768) s = -32768;
					feasible_seen++;
					// first maximum wins, a tie only reaches the runner-up
					if (!best_ok || s > best) begin
						if (best_ok) begin
							runner = best;
							runner_ok = 1;
						end
						best = s;
						best_pos = filled - 1;
						best_ok = 1;
					end else if (!runner_ok || s > runner) begin
						runner = s;
						runner_ok = 1;
					end
				end
			end
			e.feasible = (why == RSN_OK);
			e.reason_code = why;
			e.score = s[SCORE_W-1:0];
			if (w.last) begin
				e.plan_done = 1'b1;
				plans_done++;
				if (best_ok) begin
					e.chosen_index = best_pos[IDX_W-1:0];
					e.escalate_flag = (best < int'(ESCALATE_BELOW)) ||
						(runner_ok && (best - runner <= int'(ESCALATE_GAP)));
					if (e.escalate_flag) escalations++;
				end else begin
					e.plan_status = 1'b1;
				end
				filled = 0; best = 0; best_pos = 0; runner = 0;
				best_ok = 0; runner_ok = 0;
			end
			verdicts_due.push_back(e);
		endfunction

		task report(string field, longint got, longint want);
			$display("verdict %0d: %s is %0d, expected %0d", verdicts_checked, field, got, want);
			errors++;
		endtask

		task check(verdict_word_t v);
			verdict_word_t e;
			verdicts_checked++;
			if (verdicts_due.size() == 0) begin
				report("unexpected verdict, candidate_index", v.candidate_index, -1);
			end else begin
				e = verdicts_due.pop_front();
				if (v.candidate_index !== e.candidate_index)
					report("candidate_index", v.candidate_index, e.candidate_index);
				if (v.feasible !== e.feasible)
					report("feasible", v.feasible, e.feasible);
				if (v.reason_code !== e.reason_code)
					report("reason_code", v.reason_code, e.reason_code);
				if (v.score !== e.score)
					report("score", $signed(v.score), $signed(e.score));
				if (v.plan_done !== e.plan_done)
					report("plan_done", v.plan_done, e.plan_done);
				if (v.chosen_index !== e.chosen_index)
					report("chosen_index", v.chosen_index, e.chosen_index);
				if (v.plan_status !== e.plan_status)
					report("plan_status", v.plan_status, e.plan_status);
				if (v.escalate_flag !== e.escalate_flag)
					report("escalate_flag", v.escalate_flag, e.escalate_flag);
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, channels, block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	wcss_cand_if    cand_ch ();
	wcss_verdict_if verdict_ch ();

	plan_scoreboard sb = new();

	// calm: no idling on either side for the current phase
	bit calm = 1'b0;
	// long verdict hold-off, owned by the ready process
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	weighted_candidate_score_select_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cand      (cand_ch),
		.verdict   (verdict_ch)
	);

	// hard stop on a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// verdict side ready: random stalls, plus one long hold-off once enough
	// verdicts have gone by so the block fills and pushes back on cand
	always @(negedge clk) begin
		if (!hold_done && sb.verdicts_checked >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			verdict_ch.ready <= 1'b0;
		end else begin
			verdict_ch.ready <= calm || ($urandom_range(99) >= 31);
		end
	end

	// every accepted verdict word is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready)
			sb.check(verdict_ch.data);
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// offer one candidate word; entered and left just after a falling edge
	task automatic send_word(input cand_word_t w);
		while (!calm && $urandom_range(99) < 31) begin
			cand_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cand_ch.valid <= 1'b1;
		cand_ch.data  <= w;
		do @(posedge clk); while (!cand_ch.ready);
		sb.note(w);
		@(negedge clk);
	endtask

	// stop offering and wait for every pending verdict to come back
	task automatic drain();
		cand_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// write the whole register file, block idle
	task automatic load_regs(input reg_set_t s);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= s[i];
			sb.set_reg(i, s[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic cand_word_t word_of(
		logic [7:0] q, logic [7:0] g, logic [7:0] c, logic [1:0] st, logic [4:0] ef,
		logic [KEY_W-1:0] elo, logic [KEY_W-1:0] ehi, logic signed [7:0] delta,
		logic [4:0] jf, logic [KEY_W-1:0] jlo, logic [KEY_W-1:0] jhi, logic last);
		cand_word_t w;
		w.quality = q; w.gpu_load_weight = g; w.cpu_load_weight = c;
		w.engine_state = st; w.engine_flags = ef;
		w.engine_key_low = elo; w.engine_key_high = ehi;
		w.predicted_delta = delta; w.job_flags = jf;
		w.job_key_low = jlo; w.job_key_high = jhi; w.last = last;
		return w;
	endfunction

	// keys cluster near zero and near the top so ranges overlap and miss often
	function automatic logic [KEY_W-1:0] draw_key();
		int k;
		k = $urandom_range(99);
		if (k < 45)
			return KEY_W'($urandom_range(0, 40));
		else if (k < 65)
			return {32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'($urandom_range(0, 40))};
		return {$urandom, $urandom};
	endfunction

	// random plans: mostly well-formed with one job per plan, some longer
	// than capacity, and a few noise plans with every field random
	task automatic run_plans(input int n_words);
		int sent, len, k;
		bit noisy;
		logic [4:0] jf;
		logic [KEY_W-1:0] jlo, jhi;
		cand_word_t w;
		sent = 0;
		while (sent < n_words) begin
			k = $urandom_range(99);
			if (k < 75) len = $urandom_range(1, 8);
			else if (k < 90) len = $urandom_range(9, 16);
			else len = $urandom_range(17, 20);
			noisy = ($urandom_range(99) < 8);
			jf = 5'($urandom);
			jlo = draw_key();
			jhi = draw_key();
			for (int i = 0; i < len; i++) begin
				if (noisy) begin
					w = word_of(8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
						5'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
						8'($urandom), 5'($urandom), {$urandom, $urandom},
						{$urandom, $urandom}, 1'($urandom));
				end else begin
					w.quality = 8'(($urandom_range(99) < 90) ? $urandom_range(0, 100)
						: $urandom_range(101, 255));
					w.gpu_load_weight = 8'(($urandom_range(99) < 95) ? $urandom_range(0, 100)
						: $urandom_range(101, 255));
					w.cpu_load_weight = 8'(($urandom_range(99) < 95) ? $urandom_range(0, 100)
						: $urandom_range(101, 255));
					k = $urandom_range(99);
					w.engine_state = (k < 60) ? ENG_AVAILABLE : (k < 85) ? ENG_DEGRADED
						: (k < 93) ? ENG_OFFLINE : ENG_MAINTENANCE;
					w.engine_flags = 5'($urandom);
					// most engines fit the job so plans get past the checks
					if ($urandom_range(99) < 80) begin
						if (jf[JF_LOCAL_ONLY]) w.engine_flags[EF_LOCAL] = 1'b1;
						if (!jf[JF_NET_OK]) w.engine_flags[EF_NETWORK] = 1'b0;
						if (!jf[JF_REMOTE_OK]) w.engine_flags[EF_REMOTE] = 1'b0;
					end
					w.engine_key_low = draw_key();
					w.engine_key_high = draw_key();
					w.predicted_delta = 8'($urandom);
					w.job_flags = jf;
					w.job_key_low = jlo;
					w.job_key_high = jhi;
				end
				// only the plan's final word closes it, overflow words included
				w.last = (i == len - 1);
				send_word(w);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		reg_set_t s;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cand_ch.valid = 1'b0;
		cand_ch.data = '0;
		verdict_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed setting: distinct terms, gpu divisor reads as zero in its
		// low bits (acts as one), upper data bits set
		s[REG_LOCALITY_BONUS]     = 11'sd10;
		s[REG_LOCAL_FIRST_BONUS]  = 11'sd20;
		s[REG_GPU_COST_DIVISOR]   = 11'h080;
		s[REG_CPU_COST_DIVISOR]   = 11'd7;
		s[REG_DEGRADED_PENALTY]   = -11'sd30;
		s[REG_PRIVATE_DATA_BONUS] = 11'sd5;
		s[REG_OVERLAP_BONUS]      = 11'sd40;
		s[REG_MISMATCH_PENALTY]   = -11'sd50;
		load_regs(s);

		// one plan past capacity: every check, every scoring term, key range
		// corners, a tie with the best, then two overflow words
		send_word(word_of(100, 100, 100, ENG_AVAILABLE, 5'd0, 0, 0, 127, JOB_OPEN, 100, 200, 0));
		send_word(word_of(101, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, JOB_OPEN, 100, 200, 0));
		send_word(word_of(0, 255, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, JOB_OPEN, 100, 200, 0));
		send_word(word_of(0, 0, 101, ENG_AVAILABLE, 5'd0, 0, 0, 0, JOB_OPEN, 100, 200, 0));
		send_word(word_of(50, 10, 10, ENG_OFFLINE, 5'd0, 0, 0, 0, JOB_OPEN, 100, 200, 0));
		send_word(word_of(50, 10, 10, ENG_MAINTENANCE, 5'd0, 0, 0, 0, JOB_OPEN, 100, 200, 0));
		send_word(word_of(80, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0,
			JOB_OPEN | (5'd1 << JF_LOCAL_ONLY), 100, 200, 0));
		send_word(word_of(80, 0, 0, ENG_AVAILABLE, 5'd1 << EF_NETWORK, 0, 0, 0,
			5'd0, 100, 200, 0));
		send_word(word_of(80, 0, 0, ENG_AVAILABLE, 5'd1 << EF_REMOTE, 0, 0, 0,
			5'd1 << JF_NET_OK, 100, 200, 0));
		send_word(word_of(90, 20, 30, ENG_DEGRADED,
			(5'd1 << EF_LOCAL) | (5'd1 << EF_PRIVATE) | (5'd1 << EF_RANGE), 150, 300, -128,
			JOB_OPEN, 100, 200, 0));
		send_word(word_of(90, 0, 0, ENG_AVAILABLE, 5'd1 << EF_RANGE, 300, 400, 0,
			JOB_OPEN, 100, 200, 0));
		// ranges touching at one key
		send_word(word_of(60, 0, 0, ENG_AVAILABLE, 5'd1 << EF_RANGE, 200, 200, 0,
			JOB_OPEN, 100, 200, 0));
		// reversed engine range against the full key space: no overlap
		send_word(word_of(60, 0, 0, ENG_AVAILABLE, 5'd1 << EF_RANGE, KEY_TOP, 0, 0,
			JOB_OPEN, 0, KEY_TOP, 0));
		// reversed job range
		send_word(word_of(60, 0, 0, ENG_AVAILABLE, 5'd1 << EF_RANGE, 100, 200, 0,
			JOB_OPEN, 150, 120, 0));
		// engine serving only the top key
		send_word(word_of(60, 0, 0, ENG_AVAILABLE, 5'd1 << EF_RANGE, KEY_TOP, KEY_TOP, 0,
			JOB_OPEN, 0, KEY_TOP, 0));
		// same score as the first word: must not take over
		send_word(word_of(100, 100, 100, ENG_AVAILABLE, 5'd0, 0, 0, 127, JOB_OPEN, 100, 200, 0));
		send_word(word_of(0, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, -128, JOB_OPEN, 100, 200, 0));
		send_word(word_of(0, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, JOB_OPEN, 100, 200, 1));

		// plan with nothing feasible
		send_word(word_of(200, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, 5'd0, 0, 0, 1));
		// top two within the escalation gap
		send_word(word_of(70, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, 5'd0, 0, 0, 0));
		send_word(word_of(73, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, 5'd0, 0, 0, 1));
		// lone candidate below the threshold
		send_word(word_of(10, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, 5'd0, 0, 0, 1));
		// clear winner, no escalation
		send_word(word_of(100, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, 5'd0, 0, 0, 0));
		send_word(word_of(60, 0, 0, ENG_AVAILABLE, 5'd0, 0, 0, 0, 5'd0, 0, 0, 1));
		drain();

		// random phases under different settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					// top of every range
					foreach (s[i]) s[i] = 11'sd1000;
					s[REG_GPU_COST_DIVISOR] = 11'd100;
					s[REG_CPU_COST_DIVISOR] = 11'd100;
				end
				1: begin
					// bottom of every range
					foreach (s[i]) s[i] = -11'sd1000;
					s[REG_GPU_COST_DIVISOR] = 11'd1;
					s[REG_CPU_COST_DIVISOR] = 11'd1;
				end
				2: begin
					// full-width signed terms, zero and all-ones divisors
					foreach (s[i]) s[i] = CFG_W'($urandom);
					s[REG_GPU_COST_DIVISOR] = 11'd0;
					s[REG_CPU_COST_DIVISOR] = 11'h7FF;
				end
				default: begin
					foreach (s[i])
						s[i] = ($urandom_range(99) < 70) ? CFG_W'($urandom_range(0, 2000) - 1000)
							: CFG_W'($urandom);
					s[REG_GPU_COST_DIVISOR] = ($urandom_range(99) < 85)
						? CFG_W'($urandom_range(1, 100)) : CFG_W'($urandom);
					s[REG_CPU_COST_DIVISOR] = ($urandom_range(99) < 85)
						? CFG_W'($urandom_range(1, 100)) : CFG_W'($urandom);
				end
			endcase
			load_regs(s);
			// one phase with both sides streaming flat out
			calm = (p == 3);
			run_plans(PHASE_WORDS);
			drain();
		end
		calm = 1'b0;

		// let any stray verdict show up before the verdict is given
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d candidate words in %0d plans: %0d feasible, %0d overflow, %0d escalated",
			sb.words_seen, sb.plans_done, sb.feasible_seen, sb.overflow_seen, sb.escalations);
		$display("%0d register settings, one verdict hold-off of %0d cycles, %0d mismatches",
			NUM_PHASES + 1, HOLD_CYCLES, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
